FILE: sv/abkf_pkg.sv
`default_nettype none
package abkf_pkg;

  // Wide signed width for intermediate sums before saturation
  localparam int unsigned SW = 72;

  // Configuration register indexes
  localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

  // Register defaults, unsigned Q1.30
  localparam logic [30:0] ANGLE_NOISE_RST = 31'd1073742;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd3221225;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd32212255;

  // Largest accepted time step, Q0.16 (0.1 s)
  localparam logic [15:0] DT_MAX = 16'd6553;

  // Result outcome codes
  localparam logic [1:0] OC_FILTERED = 2'd0;
  localparam logic [1:0] OC_SEEDED   = 2'd1;
  localparam logic [1:0] OC_IGNORED  = 2'd2;
  localparam logic [1:0] OC_RESET    = 2'd3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'(S32_MAX);
    lo = SW'(S32_MIN);
    if (v > hi) begin
      return S32_MAX;
    end else if (v < lo) begin
      return S32_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/abkf_div.sv
`default_nettype none
// Serial restoring divider: quo = sat32((num * 2^30) / den), truncated toward zero.
// One quotient bit per cycle, done pulses with the result; a zero divisor gives zero.
module abkf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import abkf_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            st_r;
  logic [4:0]         cnt_r;
  logic [32:0]        rem_r;
  logic [30:0]        sh_r;
  logic [30:0]        q_r;
  logic [32:0]        dmag_r;
  logic               neg_r;
  logic               ovf_r;
  logic               zero_r;
  logic               done_r;
  logic signed [31:0] quo_r;

  logic [31:0] nmag_w;
  logic [32:0] dmag_w;
  logic [33:0] trial_w;
  logic        ge_w;
  logic [32:0] rem_nxt;
  logic [30:0] q_nxt;
  logic signed [31:0] qs_w;

  // Magnitudes of the operands
  assign nmag_w = num[31] ? 32'(-num) : 32'(num);
  assign dmag_w = den[32] ? 33'(-den) : 33'(den);

  // Trial subtract for one quotient bit
  assign trial_w = {rem_r, sh_r[30]};
  assign ge_w    = trial_w >= {1'b0, dmag_r};
  assign rem_nxt = ge_w ? 33'(trial_w - {1'b0, dmag_r}) : trial_w[32:0];
  assign q_nxt   = {q_r[29:0], ge_w};
  assign qs_w    = signed'({1'b0, q_nxt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            neg_r  <= num[31] ^ den[32];
            zero_r <= (den == '0);
            ovf_r  <= {2'b00, nmag_w} >= {dmag_w, 1'b0};
            dmag_r <= dmag_w;
            rem_r  <= 33'(nmag_w[31:1]);
            sh_r   <= {nmag_w[0], 30'd0};
            q_r    <= '0;
            cnt_r  <= 5'd30;
            st_r   <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt;
          sh_r  <= {sh_r[29:0], 1'b0};
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            st_r   <= D_IDLE;
            if (zero_r) begin
              quo_r <= '0;
            end else if (ovf_r) begin
              quo_r <= neg_r ? S32_MIN : S32_MAX;
            end else begin
              quo_r <= neg_r ? -qs_w : qs_w;
            end
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && st_r == D_IDLE) |=> (st_r == D_RUN && cnt_r == 5'd30))
    else $error("divider did not begin after start");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r) == D_RUN)
    else $error("divider done without a run");
  a_last_bit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_RUN && cnt_r == '0) |=> (done_r && st_r == D_IDLE))
    else $error("divider missed its last step");

endmodule
`default_nettype wire

FILE: sv/angle_bias_kalman_filter_unit.sv
`default_nettype none
// A filter update runs from the taken request through seven prediction steps, two gain
//   divisions, seven correction steps and one result step that loads the result.
// Reset, first-update seeding and ignored steps go straight from idle to the result step.
// One request at a time: no new request is taken until the sequencer is idle again; it
//   holds in its result step while the previous result waits for out_ready.
// Reset (rst_n low, synchronous): noise registers to defaults, filter state cleared, not seeded.
module angle_bias_kalman_filter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [25:0] in_measured_angle,
  input  logic signed [27:0] in_measured_rate,
  input  logic [15:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_rate_estimate,
  output logic [1:0]         out_outcome,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import abkf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RATE, ST_MANG, ST_MP11, ST_CALCA, ST_MDA, ST_MBPN, ST_P11,
    ST_DIV0, ST_DIV1, ST_MKY0, ST_MKY1, ST_MK1P0, ST_MK1P1, ST_MK0P0,
    ST_MK0P1, ST_LAST, ST_FIN
  } state_t;

  state_t             state_r;
  logic [30:0]        apn_r, bpn_r, mnoise_r;
  logic signed [31:0] angle_r, bias_r, rate_r;
  logic signed [31:0] p00_r, p01_r, p10_r, p11_r;
  logic               seeded_r;
  logic signed [25:0] meas_r;
  logic signed [27:0] mrate_r;
  logic [15:0]        dt_r;
  logic [1:0]         outc_r;
  logic signed [31:0] t_r;
  logic signed [35:0] a_r;
  logic signed [31:0] y_r, k0_r, k1_r;
  logic signed [67:0] prod_r;
  logic               out_valid_r;
  logic signed [31:0] out_angle_r, out_rate_r;
  logic [1:0]         out_outc_r;

  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] dt_s;
  logic signed [67:0] r16_w, r30_w;
  logic               dt_bad;
  logic               div_start, div_done;
  logic signed [31:0] div_num, div_quo;
  logic signed [32:0] s_w;

  assign dt_s   = signed'({16'd0, dt_r});
  assign dt_bad = (in_time_step == '0) || (in_time_step > DT_MAX);

  // Round half up of the registered product
  assign r16_w = (prod_r + 68'sd32768) >>> 16;
  assign r30_w = (prod_r + 68'sd536870912) >>> 30;

  // Innovation variance
  assign s_w = 33'(p00_r) + signed'({2'b00, mnoise_r});

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MANG:  begin mul_a = 36'(rate_r); mul_b = dt_s; end
      ST_MP11:  begin mul_a = 36'(p11_r);  mul_b = dt_s; end
      ST_MDA:   begin mul_a = a_r;         mul_b = dt_s; end
      ST_MBPN:  begin mul_a = 36'(signed'({1'b0, bpn_r})); mul_b = dt_s; end
      ST_MKY0:  begin mul_a = 36'(k0_r);   mul_b = y_r; end
      ST_MKY1:  begin mul_a = 36'(k1_r);   mul_b = y_r; end
      ST_MK1P0: begin mul_a = 36'(k1_r);   mul_b = p00_r; end
      ST_MK1P1: begin mul_a = 36'(k1_r);   mul_b = p01_r; end
      ST_MK0P0: begin mul_a = 36'(k0_r);   mul_b = p00_r; end
      ST_MK0P1: begin mul_a = 36'(k0_r);   mul_b = p01_r; end
      default:  begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  // Divider launch: k0 from P00, then k1 from P10
  assign div_start = (state_r == ST_P11) || (state_r == ST_DIV0 && div_done);
  assign div_num   = (state_r == ST_P11) ? p00_r : p10_r;

  abkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (s_w),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apn_r    <= ANGLE_NOISE_RST;
      bpn_r    <= BIAS_NOISE_RST;
      mnoise_r <= MEAS_NOISE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ANGLE_NOISE: apn_r    <= cfg_data;
        CFG_BIAS_NOISE:  bpn_r    <= cfg_data;
        CFG_MEAS_NOISE:  mnoise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    prod_r <= 68'(mul_a * mul_b);
  end

  // Sequencer, filter state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      angle_r     <= '0;
      bias_r      <= '0;
      rate_r      <= '0;
      p00_r       <= '0;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless the next one loads now
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r  <= in_measured_angle;
            mrate_r <= in_measured_rate;
            dt_r    <= in_time_step;
            if (in_operation || (!dt_bad && !seeded_r)) begin
              // seed the angle, clear bias and covariance
              angle_r  <= 32'(in_measured_angle);
              bias_r   <= '0;
              p00_r    <= '0;
              p01_r    <= '0;
              p10_r    <= '0;
              p11_r    <= '0;
              seeded_r <= 1'b1;
              outc_r   <= in_operation ? OC_RESET : OC_SEEDED;
              state_r  <= ST_FIN;
            end else if (dt_bad) begin
              outc_r  <= OC_IGNORED;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_RATE;
            end
          end
        end
        ST_RATE: begin
          rate_r  <= sat32(SW'(mrate_r) - SW'(bias_r));
          state_r <= ST_MANG;
        end
        ST_MANG: state_r <= ST_MP11;
        ST_MP11: begin
          angle_r <= sat32(SW'(angle_r) + SW'(r16_w));
          state_r <= ST_CALCA;
        end
        ST_CALCA: begin
          t_r     <= r16_w[31:0];
          a_r     <= 36'(r16_w) - 36'(p01_r) - 36'(p10_r) + 36'(signed'({1'b0, apn_r}));
          state_r <= ST_MDA;
        end
        ST_MDA: state_r <= ST_MBPN;
        ST_MBPN: begin
          p00_r   <= sat32(SW'(p00_r) + SW'(r16_w));
          p01_r   <= sat32(SW'(p01_r) - SW'(t_r));
          p10_r   <= sat32(SW'(p10_r) - SW'(t_r));
          state_r <= ST_P11;
        end
        ST_P11: begin
          p11_r   <= sat32(SW'(p11_r) + SW'(r16_w));
          y_r     <= sat32(SW'(meas_r) - SW'(angle_r));
          state_r <= ST_DIV0;
        end
        ST_DIV0: begin
          if (div_done) begin
            k0_r    <= div_quo;
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            k1_r    <= div_quo;
            state_r <= ST_MKY0;
          end
        end
        ST_MKY0: state_r <= ST_MKY1;
        ST_MKY1: begin
          angle_r <= sat32(SW'(angle_r) + SW'(r30_w));
          state_r <= ST_MK1P0;
        end
        ST_MK1P0: begin
          bias_r  <= sat32(SW'(bias_r) + SW'(r30_w));
          state_r <= ST_MK1P1;
        end
        ST_MK1P1: begin
          p10_r   <= sat32(SW'(p10_r) - SW'(r30_w));
          state_r <= ST_MK0P0;
        end
        ST_MK0P0: begin
          p11_r   <= sat32(SW'(p11_r) - SW'(r30_w));
          state_r <= ST_MK0P1;
        end
        ST_MK0P1: begin
          p00_r   <= sat32(SW'(p00_r) - SW'(r30_w));
          state_r <= ST_LAST;
        end
        ST_LAST: begin
          p01_r   <= sat32(SW'(p01_r) - SW'(r30_w));
          outc_r  <= OC_FILTERED;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_angle_r <= angle_r;
            out_rate_r  <= rate_r;
            out_outc_r  <= outc_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_angle_estimate = out_angle_r;
  assign out_rate_estimate  = out_rate_r;
  assign out_outcome        = out_outc_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");
  a_div_start_place: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == ST_P11 || state_r == ST_DIV0))
    else $error("divider started outside the gain steps");
  a_gain_to_mult: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV1 && div_done) |=> state_r == ST_MKY0)
    else $error("second gain not followed by correction");
  a_seeded_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_outc_r != OC_IGNORED) |-> seeded_r)
    else $error("result given while filter not seeded");

endmodule
`default_nettype wire

FILE: tb/angle_bias_kalman_filter_unit_checker.sv
module angle_bias_kalman_filter_unit_checker
  import abkf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operation,
  input  logic signed [25:0] in_measured_angle,
  input  logic signed [27:0] in_measured_rate,
  input  logic [15:0]        in_time_step,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_angle_estimate,
  input  logic signed [31:0] out_rate_estimate,
  input  logic [1:0]         out_outcome,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic [1:0]         outcome;
  } estimate_t;

  estimate_t estimate_q[$];

  // filter state and noise registers
  longint q_angle, q_bias, q_meas;
  logic signed [31:0] ang_s, bias_s, rate_s;
  logic signed [31:0] cov [4];
  bit seeded;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up: floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void reseed(logic signed [31:0] a);
    ang_s = a;
    bias_s = 0;
    for (int i = 0; i < 4; i++) cov[i] = 0;
    seeded = 1;
  endfunction

  function automatic estimate_t run_filter(logic op, logic signed [25:0] ma,
                                           logic signed [27:0] mr, logic [15:0] dt_in);
    estimate_t e;
    longint dt, p00, p01, p10, p11, s, k0, k1, y, a, meas;
    dt = longint'(dt_in);
    meas = longint'(ma);
    if (op) begin
      reseed(32'(meas));
      e.outcome = OC_RESET;
    end else if (dt == 0 || dt > longint'(DT_MAX)) begin
      e.outcome = OC_IGNORED;
    end else if (!seeded) begin
      reseed(32'(meas));
      e.outcome = OC_SEEDED;
    end else begin
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      k0 = 0; k1 = 0;
      // predict
      rate_s = 32'(clamp32(longint'(mr) - longint'(bias_s)));
      ang_s = 32'(clamp32(longint'(ang_s) + round_shift(dt * longint'(rate_s), 16)));
      a = round_shift(dt * p11, 16) - p01 - p10 + q_angle;
      p00 = clamp32(p00 + round_shift(dt * a, 16));
      p01 = clamp32(p01 - round_shift(dt * p11, 16));
      p10 = clamp32(p10 - round_shift(dt * p11, 16));
      p11 = clamp32(p11 + round_shift(q_bias * dt, 16));
      // correct
      s = p00 + q_meas;
      if (s != 0) begin
        k0 = clamp32((p00 * (64'sd1 <<< 30)) / s);
        k1 = clamp32((p10 * (64'sd1 <<< 30)) / s);
      end
      y = clamp32(meas - longint'(ang_s));
      ang_s = 32'(clamp32(longint'(ang_s) + round_shift(k0 * y, 30)));
      bias_s = 32'(clamp32(longint'(bias_s) + round_shift(k1 * y, 30)));
      cov[0] = 32'(clamp32(p00 - round_shift(k0 * p00, 30)));
      cov[1] = 32'(clamp32(p01 - round_shift(k0 * p01, 30)));
      cov[2] = 32'(clamp32(p10 - round_shift(k1 * p00, 30)));
      cov[3] = 32'(clamp32(p11 - round_shift(k1 * p01, 30)));
      e.outcome = OC_FILTERED;
    end
    e.angle = ang_s;
    e.rate = rate_s;
    return e;
  endfunction

  assign pending_count = estimate_q.size();

  // watch the channels, predict on each request, compare on each result
  always @(posedge clk) begin
    estimate_t want;
    if (!rst_n) begin
      q_angle <= longint'(ANGLE_NOISE_RST);
      q_bias <= longint'(BIAS_NOISE_RST);
      q_meas <= longint'(MEAS_NOISE_RST);
      ang_s = 0; bias_s = 0; rate_s = 0; seeded = 0;
      for (int i = 0; i < 4; i++) cov[i] = 0;
      estimate_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ANGLE_NOISE: q_angle <= longint'(cfg_data);
          CFG_BIAS_NOISE:  q_bias <= longint'(cfg_data);
          CFG_MEAS_NOISE:  q_meas <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        estimate_q.push_back(run_filter(in_operation, in_measured_angle,
                                        in_measured_rate, in_time_step));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (estimate_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = estimate_q.pop_front();
          if (out_angle_estimate !== want.angle || out_rate_estimate !== want.rate ||
              out_outcome !== want.outcome) begin
            fail_count <= fail_count + 1;
            if (out_angle_estimate !== want.angle)
              $error("angle_estimate exp %0d got %0d", want.angle, out_angle_estimate);
            if (out_rate_estimate !== want.rate)
              $error("rate_estimate exp %0d got %0d", want.rate, out_rate_estimate);
            if (out_outcome !== want.outcome)
              $error("outcome exp %0d got %0d", want.outcome, out_outcome);
          end
        end
      end
    end
  end
endmodule

FILE: tb/angle_bias_kalman_filter_unit_tb.sv
module angle_bias_kalman_filter_unit_tb;
  import abkf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 450;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  // request operations and an index outside the register list
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk, rst_n;
  logic in_valid, in_ready, in_operation;
  logic signed [25:0] in_measured_angle;
  logic signed [27:0] in_measured_rate;
  logic [15:0] in_time_step;
  logic out_valid, out_ready;
  logic signed [31:0] out_angle_estimate, out_rate_estimate;
  logic [1:0] out_outcome;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;
  int fail_count, pending_count, result_count;
  int idle_cycles;
  bit long_hold, drain_mode, timed_out;

  angle_bias_kalman_filter_unit u_dut (.*);

  angle_bias_kalman_filter_unit_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall per result, one long hold-off when asked
  initial begin
    int gap;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      gap = drain_mode ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18));
      repeat (gap) @(posedge clk);
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      out_ready <= 0;
    end
  end

  // watchdog: count cycles without any accepted request, result or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("angle_bias_kalman_filter_unit_tb: errors");
        $finish;
      end
    end
  end

  // valid stays high into the next request when there is no gap
  task automatic send_request(logic op, logic signed [25:0] ma, logic signed [27:0] mr,
                              logic [15:0] dt, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_measured_angle <= ma;
    in_measured_rate <= mr;
    in_time_step <= dt;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic write_register(logic [1:0] idx, logic [30:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom_range(DT_MAX + 1, 65535));
      2: return DT_MAX;
      default: return 16'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic random_phase(int count, int angle_span, bit burst);
    logic signed [25:0] ang;
    for (int i = 0; i < count; i++) begin
      ang = 26'(int'($urandom_range(0, 2 * angle_span)) - angle_span);
      if ($urandom_range(0, 29) == 0)
        send_request(OP_RESET, ang, 28'($urandom), 16'($urandom), burst);
      else if ($urandom_range(0, 19) == 0)
        send_request(OP_UPDATE, 26'($urandom), 28'($urandom), 16'($urandom), burst);
      else
        send_request(OP_UPDATE, ang, 28'(int'($urandom_range(0, 2000000)) - 1000000),
                     pick_step(), burst);
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_operation = 0; in_measured_angle = 0;
    in_measured_rate = 0; in_time_step = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    long_hold = 0; drain_mode = 0; timed_out = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: ignored steps before seeding, first update, field extremes
    send_request(OP_UPDATE, 26'sd100000, 28'sd0, 16'd0, 0);
    send_request(OP_UPDATE, 26'sd100000, 28'sd0, 16'hffff, 0);
    send_request(OP_UPDATE, 26'sd23592960, 28'sd131072000, 16'd1, 0);
    send_request(OP_UPDATE, -26'sd23592960, -28'sd131072000, DT_MAX, 0);
    send_request(OP_UPDATE, 26'sd23592960, 28'sd131072000, DT_MAX, 0);
    send_request(OP_UPDATE, 26'sd0, 28'sd65536, DT_MAX + 16'd1, 0);
    send_request(OP_RESET, 26'sh2000000, 28'sh7ffffff, 16'd0, 0);
    send_request(OP_UPDATE, 26'sh1ffffff, 28'sh8000000, 16'd1, 0);
    send_request(OP_UPDATE, 26'sd0, 28'sh7ffffff, DT_MAX, 0);
    send_request(OP_RESET, 26'sd0, 28'sd0, 16'hffff, 0);
    send_request(OP_UPDATE, 26'sd65536, 28'sd6553600, 16'd655, 0);
    wait_idle();

    // zero noise everywhere: innovation variance of zero gives zero gains
    write_register(CFG_ANGLE_NOISE, 31'd0);
    write_register(CFG_BIAS_NOISE, 31'd0);
    write_register(CFG_MEAS_NOISE, 31'd0);
    write_register(CFG_UNUSED, 31'h7fffffff);
    send_request(OP_RESET, 26'sd1000, 28'sd0, 16'd0, 0);
    send_request(OP_UPDATE, 26'sd5000, 28'sd70000, 16'd100, 0);
    send_request(OP_UPDATE, 26'sd9000, 28'sd70000, 16'd100, 0);
    wait_idle();

    // noise values of 2^30 (1.0)
    write_register(CFG_ANGLE_NOISE, 31'd1073741824);
    write_register(CFG_BIAS_NOISE, 31'd1073741824);
    write_register(CFG_MEAS_NOISE, 31'd1073741824);
    random_phase(60, 23592960, 0);
    // hold off the receiver while requests pile up
    long_hold = 1;
    random_phase(20, 23592960, 1);
    wait_idle();

    // full-range registers, then back to defaults
    write_register(CFG_ANGLE_NOISE, 31'h7fffffff);
    write_register(CFG_BIAS_NOISE, 31'h7fffffff);
    write_register(CFG_MEAS_NOISE, 31'h7fffffff);
    random_phase(60, 23592960, 0);
    wait_idle();
    write_register(CFG_ANGLE_NOISE, ANGLE_NOISE_RST);
    write_register(CFG_BIAS_NOISE, BIAS_NOISE_RST);
    write_register(CFG_MEAS_NOISE, MEAS_NOISE_RST);
    random_phase(150, 6553600, 0);
    wait_idle();

    // random noise settings
    write_register(CFG_ANGLE_NOISE, 31'($urandom_range(0, 1073741824)));
    write_register(CFG_BIAS_NOISE, 31'($urandom_range(0, 1073741824)));
    write_register(CFG_MEAS_NOISE, 31'($urandom_range(0, 1073741824)));
    random_phase(RANDOM_REQUESTS - 290, 23592960, 0);

    drain_mode = 1;
    wait_idle();
    $display("covered %0d results over reset, default, zero, extreme and random noise",
             result_count);
    $display("requests included resets, seeding, ignored steps and long receiver stalls");
    if (fail_count == 0) begin
      $display("angle_bias_kalman_filter_unit_tb: clean");
    end else begin
      $display("angle_bias_kalman_filter_unit_tb: errors");
    end
    $finish;
  end
endmodule

FILE: sim.f
sv/abkf_pkg.sv
sv/abkf_div.sv
sv/angle_bias_kalman_filter_unit.sv
tb/angle_bias_kalman_filter_unit_checker.sv
tb/angle_bias_kalman_filter_unit_tb.sv
